// ----- rtl/core/swdh_pkg.sv -----
// Package for the serial wire debug host transfer engine.
// Holds the phase type, sub-operation codes, wire sequences and word layouts.
// Depends on nothing.
package swdh_pkg;

   // Number of high clocks in a line reset.
   localparam logic [7:0] LINE_RESET_CLOCKS = 8'd60;

   // Widths of the packed stream words.
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 48;
   localparam int CSR_DATA_W = 16;

   // Command modes.
   localparam logic [2:0] MODE_TRANSFER = 3'd0;
   localparam logic [2:0] MODE_LINE_RST = 3'd1;
   localparam logic [2:0] MODE_JTAG_SWD = 3'd2;
   localparam logic [2:0] MODE_WAKEUP   = 3'd3;
   localparam logic [2:0] MODE_DORMANT  = 3'd4;

   // Register indexes.
   localparam logic CSR_RETRY_LIMIT = 1'b0;
   localparam logic CSR_WAIT_TICKS  = 1'b1;

   // Acknowledge codes.
   localparam logic [2:0] ACK_OK    = 3'd1;
   localparam logic [2:0] ACK_WAIT  = 3'd2;
   localparam logic [2:0] ACK_FAULT = 3'd4;

   // Sub-operation codes: bit 1 marks an abort write, bit 0 the RDBUFF read.
   localparam logic [1:0] SUB_MAIN         = 2'd0;
   localparam logic [1:0] SUB_RDBUFF       = 2'd1;
   localparam logic [1:0] SUB_ABORT_MAIN   = 2'd2;
   localparam logic [1:0] SUB_ABORT_RDBUFF = 2'd3;

   // Wire sequences.
   localparam logic [7:0]  REQ_FIXED_BITS = 8'h81;
   localparam logic [15:0] SWD_SELECT_SEQ = 16'hE79E;
   localparam logic [7:0]  ACTIVATION     = 8'h58;
   localparam logic [15:0] SWD_TO_DORMANT = 16'hE3BC;
   localparam logic [31:0] ABORT_VALUE    = 32'h0000_001E;
   localparam logic [31:0] ALERT_WORDS [4] = '{
      32'h49CF9046, 32'hA9B4A161, 32'h97F5BBC7, 32'h45703D98
   };

   typedef enum logic [4:0] {
      PH_IDLE, PH_REQ, PH_TRN1, PH_ACK, PH_RDATA, PH_TRN2, PH_WDATA, PH_ERRZ,
      PH_PARK, PH_BACKOFF, PH_RST_HIGH, PH_RST_LOW, PH_JTAG, PH_WAKE_HIGH,
      PH_WAKE_ALERT, PH_WAKE_LOW, PH_WAKE_ACT, PH_DORM_HIGH, PH_DORM_SEQ
   } phase_type;

endpackage

// ----- rtl/core/swd_host_transfer_engine.sv -----
// Top level of the serial wire debug host transfer engine.
// Sequencer for transfers and line sequences with a registered result word.
// Depends on swdh_pkg.
//
// Usage: every word on the req_ channel is one wire clock period. It carries
// the sampled data pin and, while the host is idle, an optional command. For
// every request word exactly one response word comes back on rsp_, giving the
// pin level to drive, the drive enable, the clock pulse and the command status.
// The result is registered and appears on rsp_ in the cycle after its word is accepted.
// Throughput is one word per cycle while rsp_ takes each result; the phase
// sequencer updates in the same cycle in which a word is accepted.
// The result register stands between the channels: req_tready stays high while
// the held result is taken, and drops only while a result waits unaccepted.
// The csr_ port writes retry_limit (index 0) and wait_backoff_ticks (index 1);
// write it only while the engine is idle.
// Reset (synchronous, active high) returns the engine to idle with the host
// driving the pin, the registers at 10 and 1000, and no result pending.
// No clearing pass follows reset.
module swd_host_transfer_engine (
   input  logic clock,
   input  logic reset,
   // start_req[0], mode[3:1], access_port[4], read_not_write[5],
   // reg_addr[7:6], write_data[39:8], line_in[40], zeros above
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [swdh_pkg::REQ_DATA_W-1:0]     req_tdata,
   // line_out[0], line_drive[1], swclk_pulse[2], busy_res[3], done_res[4],
   // status[5], last_ack[8:6], parity_error[9], read_data[41:10], zeros above
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [swdh_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_we,
   input  logic                                csr_addr,
   input  logic [swdh_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import swdh_pkg::*;

   // State registers.
   phase_type   phase_ff, phase_in;
   logic [7:0]  cnt_ff, cnt_in;
   logic [31:0] shift_ff, shift_in;
   logic        par_ff, par_in;
   logic        hdrv_ff, hdrv_in;
   logic [3:0]  att_ff, att_in;
   logic [15:0] boff_ff, boff_in;
   logic        cap_ff, cap_in;
   logic        crnw_ff, crnw_in;
   logic [1:0]  caddr_ff, caddr_in;
   logic [31:0] cwdata_ff, cwdata_in;
   logic [1:0]  sub_ff, sub_in;
   logic [2:0]  ackr_ff, ackr_in;
   logic [2:0]  sack_ff, sack_in;
   logic        perr_ff, perr_in;
   logic [3:0]  limit_ff;
   logic [15:0] wticks_ff;
   logic        rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Request fields.
   logic        f_start, f_ap, f_rnw, f_lin;
   logic [2:0]  f_mode;
   logic [1:0]  f_addr;
   logic [31:0] f_wdata;
   logic        accept;

   assign f_start = req_tdata[0];
   assign f_mode  = req_tdata[3:1];
   assign f_ap    = req_tdata[4];
   assign f_rnw   = req_tdata[5];
   assign f_addr  = req_tdata[7:6];
   assign f_wdata = req_tdata[39:8];
   assign f_lin   = req_tdata[40];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Per-word sequencer: command start, then one wire period of the phase.
   always_comb begin
      logic        o_line, o_drive, o_clk, o_done, o_status, o_busy;
      logic [31:0] o_data;
      logic        c_ap, c_rnw, c_bad, retry;
      logic [1:0]  c_addr;
      logic [31:0] c_wdata;
      logic [7:0]  req_byte, cnt_inc;
      logic [31:0] alert;
      logic [2:0]  ack_new;
      logic [3:0]  att_new;

      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      shift_in  = shift_ff;
      par_in    = par_ff;
      hdrv_in   = hdrv_ff;
      att_in    = att_ff;
      boff_in   = boff_ff;
      cap_in    = cap_ff;
      crnw_in   = crnw_ff;
      caddr_in  = caddr_ff;
      cwdata_in = cwdata_ff;
      sub_in    = sub_ff;
      ackr_in   = ackr_ff;
      sack_in   = sack_ff;
      perr_in   = perr_ff;

      o_line   = 1'b0;
      o_drive  = hdrv_ff;
      o_clk    = 1'b0;
      o_done   = 1'b0;
      o_status = 1'b0;
      o_data   = '0;

      // Command start takes effect in the same period.
      if (phase_ff == PH_IDLE && f_start && f_mode <= MODE_DORMANT) begin
         cap_in    = f_ap;
         crnw_in   = f_rnw;
         caddr_in  = f_addr;
         cwdata_in = f_wdata;
         sub_in    = SUB_MAIN;
         att_in    = '0;
         sack_in   = '0;
         perr_in   = 1'b0;
         ackr_in   = '0;
         cnt_in    = '0;
         unique case (f_mode)
            MODE_TRANSFER: begin
               phase_in = PH_REQ;
               shift_in = '0;
               par_in   = 1'b0;
            end
            MODE_LINE_RST: phase_in = PH_RST_HIGH;
            MODE_JTAG_SWD: phase_in = PH_JTAG;
            MODE_WAKEUP:   phase_in = PH_WAKE_HIGH;
            default:       phase_in = PH_DORM_HIGH;
         endcase
      end
      o_busy = (phase_in != PH_IDLE);

      // Fields of the current transfer by sub-operation.
      c_ap    = (sub_in == SUB_MAIN) ? cap_in : 1'b0;
      c_rnw   = (sub_in == SUB_MAIN) ? crnw_in : (sub_in == SUB_RDBUFF);
      c_addr  = (sub_in == SUB_MAIN) ? caddr_in : ((sub_in == SUB_RDBUFF) ? 2'd3 : 2'd0);
      c_wdata = sub_in[1] ? ABORT_VALUE : cwdata_in;
      req_byte = REQ_FIXED_BITS | {2'b00, c_ap ^ c_rnw ^ c_addr[0] ^ c_addr[1],
                                   c_addr, c_rnw, c_ap, 1'b0};
      cnt_inc = cnt_in + 8'd1;
      alert   = ALERT_WORDS[cnt_in[6:5]];
      ack_new = '0;
      c_bad   = (ackr_in == ACK_OK) && c_rnw && par_in;
      att_new = att_in;
      retry   = 1'b0;

      unique case (phase_in)
         PH_IDLE: begin
         end
         PH_REQ: begin
            o_line = req_byte[cnt_in[2:0]]; o_drive = 1'b1; o_clk = 1'b1; hdrv_in = 1'b1;
            cnt_in = cnt_inc;
            if (cnt_inc >= 8'd8) begin
               phase_in = PH_TRN1;
               cnt_in   = '0;
            end
         end
         PH_TRN1: begin
            o_drive = 1'b0; o_clk = 1'b1;
            hdrv_in  = 1'b0;
            phase_in = PH_ACK;
            cnt_in   = '0;
            shift_in = '0;
         end
         PH_ACK: begin
            o_drive = 1'b0; o_clk = 1'b1;
            shift_in[cnt_in[1:0]] = shift_in[cnt_in[1:0]] | f_lin;
            cnt_in = cnt_inc;
            if (cnt_inc >= 8'd3) begin
               ack_new  = shift_in[2:0];
               ackr_in  = ack_new;
               shift_in = '0;
               cnt_in   = '0;
               phase_in = (ack_new == ACK_OK && c_rnw) ? PH_RDATA : PH_TRN2;
            end
         end
         PH_RDATA: begin
            o_drive = 1'b0; o_clk = 1'b1;
            par_in  = par_in ^ f_lin;
            if (cnt_in < 8'd32) begin
               shift_in[cnt_in[4:0]] = shift_in[cnt_in[4:0]] | f_lin;
               cnt_in = cnt_inc;
            end else begin
               cnt_in   = '0;
               phase_in = PH_TRN2;
            end
         end
         PH_TRN2: begin
            o_drive = 1'b0; o_clk = 1'b1;
            hdrv_in = 1'b1;
            cnt_in  = '0;
            if (ackr_in == ACK_OK) begin
               if (c_rnw) phase_in = PH_PARK;
               else begin
                  shift_in = c_wdata;
                  phase_in = PH_WDATA;
               end
            end else begin
               phase_in = PH_ERRZ;
            end
         end
         PH_WDATA: begin
            o_drive = 1'b1; o_clk = 1'b1; hdrv_in = 1'b1;
            if (cnt_in < 8'd32) begin
               o_line = shift_in[cnt_in[4:0]];
               cnt_in = cnt_inc;
            end else begin
               o_line   = ^shift_in;
               cnt_in   = '0;
               phase_in = PH_PARK;
            end
         end
         PH_ERRZ: begin
            o_drive = 1'b1; o_clk = 1'b1; hdrv_in = 1'b1;
            cnt_in = cnt_inc;
            if (cnt_inc >= 8'd32) begin
               cnt_in   = '0;
               phase_in = PH_PARK;
            end
         end
         PH_PARK: begin
            o_drive = 1'b1; o_clk = 1'b1; hdrv_in = 1'b1;
            // End of one attempt: decide on finish, RDBUFF read, retry, backoff or abort.
            if (sub_in[1]) begin
               sub_in = {1'b0, sub_in[0]};
               retry  = 1'b1;
            end else begin
               if (att_in < 4'd15) att_new = att_in + 4'd1;
               att_in  = att_new;
               sack_in = ackr_in;
               if (c_rnw) perr_in = c_bad;
               if (ackr_in == ACK_OK && !c_bad) begin
                  if (sub_in == SUB_MAIN && c_ap && c_rnw) begin
                     sub_in   = SUB_RDBUFF;
                     att_in   = '0;
                     phase_in = PH_REQ;
                     cnt_in   = '0;
                     shift_in = '0;
                     par_in   = 1'b0;
                  end else begin
                     o_done   = 1'b1;
                     o_data   = c_rnw ? shift_in : '0;
                     phase_in = PH_IDLE;
                     cnt_in   = '0;
                  end
               end else if (ackr_in == ACK_WAIT) begin
                  boff_in = wticks_ff;
                  if (wticks_ff == '0) retry = 1'b1;
                  else phase_in = PH_BACKOFF;
               end else if (ackr_in == ACK_FAULT || c_bad) begin
                  sub_in   = {1'b1, sub_in[0]};
                  phase_in = PH_REQ;
                  cnt_in   = '0;
                  shift_in = '0;
                  par_in   = 1'b0;
               end else begin
                  retry = 1'b1;
               end
            end
         end
         PH_BACKOFF: begin
            if (boff_in > '0) boff_in = boff_in - 16'd1;
            if (boff_in == '0) retry = 1'b1;
         end
         PH_RST_HIGH: begin
            o_line = 1'b1; o_drive = 1'b1; o_clk = 1'b1; hdrv_in = 1'b1;
            cnt_in = cnt_inc;
            if (cnt_inc >= LINE_RESET_CLOCKS) begin
               cnt_in   = '0;
               phase_in = PH_RST_LOW;
            end
         end
         PH_RST_LOW: begin
            o_drive = 1'b1; o_clk = 1'b1; hdrv_in = 1'b1;
            o_done   = 1'b1;
            phase_in = PH_IDLE;
            cnt_in   = '0;
         end
         PH_JTAG: begin
            o_line = SWD_SELECT_SEQ[cnt_in[3:0]]; o_drive = 1'b1; o_clk = 1'b1;
            hdrv_in = 1'b1;
            cnt_in = cnt_inc;
            if (cnt_inc >= 8'd16) begin
               cnt_in   = '0;
               phase_in = PH_RST_HIGH;
            end
         end
         PH_WAKE_HIGH: begin
            o_line = 1'b1; o_drive = 1'b1; o_clk = 1'b1; hdrv_in = 1'b1;
            cnt_in = cnt_inc;
            if (cnt_inc >= 8'd8) begin
               cnt_in   = '0;
               phase_in = PH_WAKE_ALERT;
            end
         end
         PH_WAKE_ALERT: begin
            o_line = alert[5'd31 - cnt_in[4:0]]; o_drive = 1'b1; o_clk = 1'b1;
            hdrv_in = 1'b1;
            cnt_in = cnt_inc;
            if (cnt_inc >= 8'd128) begin
               cnt_in   = '0;
               phase_in = PH_WAKE_LOW;
            end
         end
         PH_WAKE_LOW: begin
            o_drive = 1'b1; o_clk = 1'b1; hdrv_in = 1'b1;
            cnt_in = cnt_inc;
            if (cnt_inc >= 8'd4) begin
               cnt_in   = '0;
               phase_in = PH_WAKE_ACT;
            end
         end
         PH_WAKE_ACT: begin
            o_line = ACTIVATION[3'd7 - cnt_in[2:0]]; o_drive = 1'b1; o_clk = 1'b1;
            hdrv_in = 1'b1;
            cnt_in = cnt_inc;
            if (cnt_inc >= 8'd8) begin
               cnt_in   = '0;
               phase_in = PH_RST_HIGH;
            end
         end
         PH_DORM_HIGH: begin
            o_line = 1'b1; o_drive = 1'b1; o_clk = 1'b1; hdrv_in = 1'b1;
            cnt_in = cnt_inc;
            if (cnt_inc >= LINE_RESET_CLOCKS) begin
               cnt_in   = '0;
               phase_in = PH_DORM_SEQ;
            end
         end
         PH_DORM_SEQ: begin
            o_line = SWD_TO_DORMANT[cnt_in[3:0]]; o_drive = 1'b1; o_clk = 1'b1;
            hdrv_in = 1'b1;
            cnt_in = cnt_inc;
            if (cnt_inc >= 8'd16) begin
               o_done   = 1'b1;
               phase_in = PH_IDLE;
               cnt_in   = '0;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            cnt_in   = '0;
         end
      endcase

      // Retry while attempts remain, else report failure.
      if (retry) begin
         if (att_in < limit_ff) begin
            phase_in = PH_REQ;
            cnt_in   = '0;
            shift_in = '0;
            par_in   = 1'b0;
         end else begin
            o_done   = 1'b1;
            o_status = 1'b1;
            phase_in = PH_IDLE;
            cnt_in   = '0;
         end
      end

      rsp_data_in = {6'd0, o_data, perr_in, sack_in, o_status, o_done, o_busy,
                     o_clk, o_drive, o_line};
   end

   // State, configuration and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         cnt_ff       <= '0;
         shift_ff     <= '0;
         par_ff       <= 1'b0;
         hdrv_ff      <= 1'b1;
         att_ff       <= '0;
         boff_ff      <= '0;
         cap_ff       <= 1'b0;
         crnw_ff      <= 1'b0;
         caddr_ff     <= '0;
         cwdata_ff    <= '0;
         sub_ff       <= SUB_MAIN;
         ackr_ff      <= '0;
         sack_ff      <= '0;
         perr_ff      <= 1'b0;
         limit_ff     <= 4'd10;
         wticks_ff    <= 16'd1000;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff     <= phase_in;
            cnt_ff       <= cnt_in;
            shift_ff     <= shift_in;
            par_ff       <= par_in;
            hdrv_ff      <= hdrv_in;
            att_ff       <= att_in;
            boff_ff      <= boff_in;
            cap_ff       <= cap_in;
            crnw_ff      <= crnw_in;
            caddr_ff     <= caddr_in;
            cwdata_ff    <= cwdata_in;
            sub_ff       <= sub_in;
            ackr_ff      <= ackr_in;
            sack_ff      <= sack_in;
            perr_ff      <= perr_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            unique case (csr_addr)
               CSR_RETRY_LIMIT: limit_ff  <= csr_wdata[3:0];
               default:         wticks_ff <= csr_wdata;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) rsp_data_ff <= rsp_data_in;
   end

   // A completing word always belongs to a busy command.
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[4] |-> rsp_data_ff[3])
      else $error("done without busy");

   // A released pin is always clocked and reads low.
   a_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff[1] |-> rsp_data_ff[2] && !rsp_data_ff[0])
      else $error("released pin without clock or with high level");

   // The bit counter is clear whenever the engine rests idle.
   a_idle_cnt: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> cnt_ff == '0)
      else $error("idle with bit counter set");

   // Failure is only reported with done.
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[5] |-> rsp_data_ff[4])
      else $error("status without done");

endmodule
